// ===== design/sobel_pkg.sv =====
`default_nettype none
package sobel_pkg;

    localparam int GRAY_W             = 8;
    localparam int ROW_W              = 12;
    localparam int OUT_COL_W          = 12;
    localparam int CFG_DATA_W         = 13;
    localparam int CFG_INDEX_W        = 4;
    localparam int ROW_LIMIT          = 4096;
    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_QUEUE_DEPTH = 4;
    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;
    localparam logic [GRAY_W-1:0] SAT_VALUE = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

    // one classified pixel handed from front to back (column travels beside it)
    typedef struct packed {
        logic [GRAY_W-1:0] up;
        logic [GRAY_W-1:0] mid;
        logic [GRAY_W-1:0] gray;
        logic [ROW_W-1:0]  row;
        logic              col_last;
        logic              row_last;
    } item_t;

endpackage
`default_nettype wire

// ===== design/sobel_queue.sv =====
`default_nettype none
module sobel_queue import sobel_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/sobel_front.sv =====
`default_nettype none
module sobel_front import sobel_pkg::*; #(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [GRAY_W-1:0]      s_red_in,
    input  wire logic [GRAY_W-1:0]      s_green_in,
    input  wire logic [GRAY_W-1:0]      s_blue_in,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        q_valid,
    input  wire logic                   q_ready,
    output item_t                       q_item,
    output logic [COL_W-1:0]            q_col,
    output logic                        win_clear
);

    localparam int RESET_W = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
    localparam logic [COL_W-1:0] RESET_LAST_COL = COL_W'(RESET_W - 1);
    localparam logic [ROW_W-1:0] RESET_LAST_ROW = ROW_W'(RESET_FRAME_HEIGHT - 1);
    localparam logic [COL_W-1:0] MAX_LAST_COL   = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] MAX_LAST_ROW   = ROW_W'(ROW_LIMIT - 1);

    logic [GRAY_W-1:0] line_upper_mem  [MAX_WIDTH];
    logic [GRAY_W-1:0] line_middle_mem [MAX_WIDTH];

    logic [COL_W-1:0]  last_col_reg;
    logic [ROW_W-1:0]  last_row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic              st1_valid_reg;
    logic [GRAY_W-1:0] st1_gray_reg;
    logic [COL_W-1:0]  st1_col_reg;
    logic [ROW_W-1:0]  st1_row_reg;
    logic              st1_col_last_reg;
    logic              st1_row_last_reg;
    logic [GRAY_W-1:0] up_rd_reg;
    logic [GRAY_W-1:0] mid_rd_reg;

    logic              accept;
    logic              push;
    logic              col_last;
    logic              row_last;
    logic              cfg_hit;
    logic [12:0]       gray_sum;
    logic [COL_W-1:0]  width_last;
    logic [ROW_W-1:0]  height_last;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    assign win_clear = cfg_hit;

    assign push    = st1_valid_reg && q_ready;
    assign s_ready = !st1_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    assign col_last = (col_reg == last_col_reg);
    assign row_last = (row_reg == last_row_reg);

    assign gray_sum = ({5'd0, s_red_in} * 13'd11) + {1'b0, s_green_in, 4'd0}
                    + ({5'd0, s_blue_in} * 13'd5);

    // last column and last row from the clamped frame size
    always_comb begin
        if (cfg_data < 13'd3) begin
            width_last = COL_W'(2);
        end else if ({1'b0, cfg_data} > 14'(MAX_WIDTH)) begin
            width_last = MAX_LAST_COL;
        end else begin
            width_last = COL_W'(cfg_data - 13'd1);
        end
        if (cfg_data < 13'd3) begin
            height_last = ROW_W'(2);
        end else if (cfg_data > 13'(ROW_LIMIT)) begin
            height_last = MAX_LAST_ROW;
        end else begin
            height_last = ROW_W'(cfg_data - 13'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg  <= RESET_LAST_COL;
            last_row_reg  <= RESET_LAST_ROW;
            col_reg       <= '0;
            row_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == REG_FRAME_WIDTH) begin
                last_col_reg <= width_last;
            end
            if (cfg_valid && cfg_index == REG_FRAME_HEIGHT) begin
                last_row_reg <= height_last;
            end
            if (cfg_hit) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (accept) begin
                if (col_last) begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (push) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_gray_reg     <= gray_sum[12:5];
            st1_col_reg      <= col_reg;
            st1_row_reg      <= row_reg;
            st1_col_last_reg <= col_last;
            st1_row_last_reg <= row_last;
        end
    end

    // line stores: read on accept, rotate on hand-off to the queue
    always_ff @(posedge aclk) begin
        if (accept) begin
            up_rd_reg  <= line_upper_mem[col_reg];
            mid_rd_reg <= line_middle_mem[col_reg];
        end
        if (push) begin
            line_upper_mem[st1_col_reg]  <= mid_rd_reg;
            line_middle_mem[st1_col_reg] <= st1_gray_reg;
        end
    end

    assign q_valid         = st1_valid_reg;
    assign q_col           = st1_col_reg;
    assign q_item.up       = up_rd_reg;
    assign q_item.mid      = mid_rd_reg;
    assign q_item.gray     = st1_gray_reg;
    assign q_item.row      = st1_row_reg;
    assign q_item.col_last = st1_col_last_reg;
    assign q_item.row_last = st1_row_last_reg;

endmodule
`default_nettype wire

// ===== design/sobel_back.sv =====
`default_nettype none
module sobel_back import sobel_pkg::*; #(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              win_clear,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire item_t             q_item,
    input  wire logic [COL_W-1:0]  q_col,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [GRAY_W-1:0]      m_edge_value,
    output logic [OUT_COL_W-1:0]   m_out_col,
    output logic [ROW_W-1:0]       m_out_row,
    output logic                   m_last_of_run
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_GRAD = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t            state_reg;
    logic [GRAY_W-1:0] win_reg [9];
    item_t             cur_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [2:0]        pend_reg;
    logic              interior_reg;
    logic [9:0]        gx_abs_reg;
    logic [9:0]        gy_abs_reg;
    logic [15:0]       val_reg;
    logic              sat_reg;
    logic [10:0]       rem_reg;
    logic [7:0]        root_reg;
    logic [2:0]        iter_reg;

    logic              m_valid_reg;
    logic [GRAY_W-1:0] m_edge_value_reg;
    logic [OUT_COL_W-1:0] m_out_col_reg;
    logic [ROW_W-1:0]  m_out_row_reg;
    logic              m_last_of_run_reg;

    logic              pop;
    logic              has_first;
    logic              is_interior;
    logic [2:0]        pend_new;
    logic [9:0]        gx_pos;
    logic [9:0]        gx_neg;
    logic [9:0]        gy_pos;
    logic [9:0]        gy_neg;
    logic [20:0]       sq_sum;
    logic [10:0]       rem_shift;
    logic [10:0]       root_test;
    logic              out_free;
    logic              emit;
    logic [2:0]        pend_after;
    logic [GRAY_W-1:0] emit_value;
    logic [COL_W-1:0]  emit_col;
    logic [ROW_W-1:0]  emit_row;

    assign q_ready = (state_reg == ST_IDLE);
    assign pop     = q_valid && q_ready;

    assign has_first   = (q_item.row != '0) && (q_col != '0);
    assign is_interior = has_first && (q_col > COL_W'(1)) && (q_item.row > ROW_W'(1));
    assign pend_new    = {q_item.row_last, (q_item.row != '0) && q_item.col_last, has_first};

    assign gx_pos = {2'd0, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'd0, win_reg[8]};
    assign gx_neg = {2'd0, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'd0, win_reg[6]};
    assign gy_pos = {2'd0, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'd0, win_reg[2]};
    assign gy_neg = {2'd0, win_reg[6]} + {1'b0, win_reg[7], 1'b0} + {2'd0, win_reg[8]};

    assign sq_sum = ({11'd0, gx_abs_reg} * {11'd0, gx_abs_reg})
                  + ({11'd0, gy_abs_reg} * {11'd0, gy_abs_reg});

    assign rem_shift = {rem_reg[8:0], val_reg[15:14]};
    assign root_test = {1'b0, root_reg, 2'b01};

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg == ST_EMIT) && out_free;

    always_comb begin
        if (pend_reg[0]) begin
            pend_after = pend_reg & 3'b110;
            emit_col   = cur_col_reg - 1'b1;
            emit_row   = cur_reg.row - 1'b1;
            if (!interior_reg) begin
                emit_value = win_reg[4];
            end else if (sat_reg) begin
                emit_value = SAT_VALUE;
            end else begin
                emit_value = root_reg;
            end
        end else if (pend_reg[1]) begin
            pend_after = pend_reg & 3'b100;
            emit_col   = cur_col_reg;
            emit_row   = cur_reg.row - 1'b1;
            emit_value = cur_reg.mid;
        end else begin
            pend_after = 3'b000;
            emit_col   = cur_col_reg;
            emit_row   = cur_reg.row;
            emit_value = cur_reg.gray;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= '0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (win_clear) begin
                for (int i = 0; i < 9; i++) begin
                    win_reg[i] <= '0;
                end
            end else if (pop) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= q_item.up;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= q_item.mid;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= q_item.gray;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        pend_reg <= pend_new;
                        if (is_interior) begin
                            state_reg <= ST_GRAD;
                        end else if (pend_new != 3'b000) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_GRAD: begin
                    state_reg <= ST_SQR;
                end
                ST_SQR: begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (iter_reg == 3'd7) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit) begin
                        pend_reg <= pend_after;
                        if (pend_after == 3'b000) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg      <= q_item;
            cur_col_reg  <= q_col;
            interior_reg <= is_interior;
        end
        if (state_reg == ST_GRAD) begin
            gx_abs_reg <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            gy_abs_reg <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        end
        if (state_reg == ST_SQR) begin
            sat_reg  <= (sq_sum[20:16] != '0);
            val_reg  <= sq_sum[15:0];
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= '0;
        end
        // one result bit per cycle, restoring square root
        if (state_reg == ST_ROOT) begin
            if (rem_shift >= root_test) begin
                rem_reg  <= rem_shift - root_test;
                root_reg <= {root_reg[6:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[6:0], 1'b0};
            end
            val_reg  <= {val_reg[13:0], 2'b00};
            iter_reg <= iter_reg + 1'b1;
        end
        if (emit) begin
            m_edge_value_reg  <= emit_value;
            m_out_col_reg     <= OUT_COL_W'(emit_col);
            m_out_row_reg     <= emit_row;
            m_last_of_run_reg <= (pend_after == 3'b000);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_edge_value  = m_edge_value_reg;
    assign m_out_col     = m_out_col_reg;
    assign m_out_row     = m_out_row_reg;
    assign m_last_of_run = m_last_of_run_reg;

endmodule
`default_nettype wire

// ===== design/sobel_edge_detector.sv =====
// Streaming 3x3 Sobel edge detector.
// Input channel (s_valid/s_ready): one RGB pixel per item, raster order.
// Result channel (m_valid/m_ready): edge_value with its column and row; each
// pixel causes 0 to 3 results, the final one flagged by m_last_of_run.
// Interior results trail the input by one row and one column; the bottom row
// is emitted as it arrives. Border pixels report their gray value.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 frame width,
// index 1 frame height; either write restarts the frame at pixel (0,0).
// The front takes a pixel every cycle into a small queue while it has room;
// line store reads are registered at accept. The back unit takes one item
// at a time: border-only items go straight from idle to emit, one result
// per emit; interior pixels first pass gradient, squares and an 8-step
// square root before they reach emit.
// A stalled m_ready holds the output register; the queue absorbs input
// until full, then s_ready drops.
// Reset: frame size 640x480, position (0,0), window cleared; line store
// contents are left as they are.
`default_nettype none
module sobel_edge_detector import sobel_pkg::*; #(
    parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [GRAY_W-1:0]      s_red_in,
    input  wire logic [GRAY_W-1:0]      s_green_in,
    input  wire logic [GRAY_W-1:0]      s_blue_in,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [GRAY_W-1:0]           m_edge_value,
    output logic [OUT_COL_W-1:0]        m_out_col,
    output logic [ROW_W-1:0]            m_out_row,
    output logic                        m_last_of_run,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ITEM_W = $bits(item_t) + COL_W;

    logic              fq_valid;
    logic              fq_ready;
    item_t             fq_item;
    logic [COL_W-1:0]  fq_col;
    logic              qb_valid;
    logic              qb_ready;
    logic [ITEM_W-1:0] qb_data;
    item_t             qb_item;
    logic [COL_W-1:0]  qb_col;
    logic              win_clear;

    assign {qb_item, qb_col} = qb_data;

    sobel_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_item     (fq_item),
        .q_col      (fq_col),
        .win_clear  (win_clear)
    );

    sobel_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_item, fq_col}),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    sobel_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .win_clear     (win_clear),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .q_item        (qb_item),
        .q_col         (qb_col),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_value  (m_edge_value),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_sobel_edge_detector.sv =====
`timescale 1ns / 100ps
module tb_sobel_edge_detector;
    import sobel_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 210;
    localparam int PRINT_LIMIT   = 30;
    localparam int MIN_SIZE      = 3;
    localparam int SQUARE_LIMIT  = 65536;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 4'd15;

    localparam logic [23:0] CORNER_FRAME [9] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000,
        24'h00FF00, 24'h0000FF, 24'hFFFFFF,
        24'h000000, 24'h808080, 24'h7F7F7F
    };
    localparam logic [23:0] STEP_FRAME [9] = '{
        24'h000000, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'hFFFFFF, 24'hFFFFFF,
        24'h000000, 24'hFFFFFF, 24'hFFFFFF
    };

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {LEVELS_RANDOM, LEVELS_EXTREME, LEVELS_FLAT} level_style_t;

    typedef struct packed {
        logic [GRAY_W-1:0]    level;
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } edge_result_t;

    class sobel_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        logic [GRAY_W-1:0]     line_upper [DEFAULT_MAX_WIDTH];
        logic [GRAY_W-1:0]     line_middle [DEFAULT_MAX_WIDTH];
        logic [GRAY_W-1:0]     taps [9];
        int unsigned           col_pos;
        int unsigned           row_pos;
        edge_result_t          pending [$];
        int                    errors;
        int                    checked;
        int                    pixels;
        int                    reg_writes;

        function void restart_frame();
            foreach (taps[i]) taps[i] = '0;
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void reset_state();
            width_reg  = RESET_FRAME_WIDTH;
            height_reg = RESET_FRAME_HEIGHT;
            foreach (line_upper[i]) begin
                line_upper[i]  = '0;
                line_middle[i] = '0;
            end
            restart_frame();
            pending.delete();
            errors     = 0;
            checked    = 0;
            pixels     = 0;
            reg_writes = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (index == REG_FRAME_WIDTH) begin
                width_reg = data;
                restart_frame();
            end else if (index == REG_FRAME_HEIGHT) begin
                height_reg = data;
                restart_frame();
            end
        endfunction

        function int unsigned clamp_size(int unsigned size, int unsigned top);
            if (size < MIN_SIZE) return MIN_SIZE;
            if (size > top) return top;
            return size;
        endfunction

        function logic [GRAY_W-1:0] magnitude();
            int          t [9];
            int          gx;
            int          gy;
            int unsigned sum;
            int unsigned root;
            int unsigned trial;
            foreach (t[i]) t[i] = taps[i];
            gx = (t[2] + 2 * t[5] + t[8]) - (t[0] + 2 * t[3] + t[6]);
            gy = (t[0] + 2 * t[1] + t[2]) - (t[6] + 2 * t[7] + t[8]);
            sum = gx * gx + gy * gy;
            if (sum >= SQUARE_LIMIT) return SAT_VALUE;
            root = 0;
            for (int b = GRAY_W - 1; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= sum) root = trial;
            end
            return root[GRAY_W-1:0];
        endfunction

        function edge_result_t make_result(logic [GRAY_W-1:0] level, int unsigned col,
                                           int unsigned row);
            edge_result_t res;
            res.level = level;
            res.col   = col[OUT_COL_W-1:0];
            res.row   = row[ROW_W-1:0];
            res.last  = 1'b0;
            return res;
        endfunction

        function void note_pixel(logic [GRAY_W-1:0] red, logic [GRAY_W-1:0] green,
                                 logic [GRAY_W-1:0] blue);
            int unsigned       w;
            int unsigned       h;
            int unsigned       c;
            int unsigned       r;
            int unsigned       sum;
            logic [GRAY_W-1:0] gray;
            logic [GRAY_W-1:0] up;
            logic [GRAY_W-1:0] mid;
            logic [GRAY_W-1:0] level;
            edge_result_t      found [$];
            w = clamp_size(width_reg, DEFAULT_MAX_WIDTH);
            h = clamp_size(height_reg, ROW_LIMIT);
            c = col_pos;
            r = row_pos;
            if (c >= w) c = w - 1;
            if (r >= h) r = h - 1;
            sum  = 11 * red + 16 * green + 5 * blue;
            gray = GRAY_W'(sum >> 5);
            up   = line_upper[c];
            mid  = line_middle[c];
            taps[0] = taps[1]; taps[1] = taps[2]; taps[2] = up;
            taps[3] = taps[4]; taps[4] = taps[5]; taps[5] = mid;
            taps[6] = taps[7]; taps[7] = taps[8]; taps[8] = gray;
            line_upper[c]  = mid;
            line_middle[c] = gray;
            if (r >= 1 && c >= 1) begin
                level = (c >= 2 && r >= 2) ? magnitude() : taps[4];
                found.push_back(make_result(level, c - 1, r - 1));
            end
            if (r >= 1 && c == w - 1) found.push_back(make_result(mid, c, r - 1));
            if (r == h - 1) found.push_back(make_result(gray, c, r));
            if (found.size() > 0) found[found.size() - 1].last = 1'b1;
            foreach (found[i]) pending.push_back(found[i]);
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
            pixels++;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [GRAY_W-1:0] level, logic [OUT_COL_W-1:0] col,
                          logic [ROW_W-1:0] row, logic last);
            edge_result_t want;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %0d at col %0d row %0d", level, col, row));
                return;
            end
            want = pending.pop_front();
            if (level !== want.level)
                report($sformatf("edge_value %0d, expected %0d (col %0d row %0d)",
                                 level, want.level, want.col, want.row));
            if (col !== want.col)
                report($sformatf("out_col %0d, expected %0d", col, want.col));
            if (row !== want.row)
                report($sformatf("out_row %0d, expected %0d", row, want.row));
            if (last !== want.last)
                report($sformatf("last_of_run %0b, expected %0b (col %0d row %0d)",
                                 last, want.last, want.col, want.row));
        endtask

        task check_leftover();
            if (pending.size() != 0)
                report($sformatf("%0d expected results never arrived", pending.size()));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [GRAY_W-1:0]      s_red_in = '0;
    logic [GRAY_W-1:0]      s_green_in = '0;
    logic [GRAY_W-1:0]      s_blue_in = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [GRAY_W-1:0]      m_edge_value;
    logic [OUT_COL_W-1:0]   m_out_col;
    logic [ROW_W-1:0]       m_out_row;
    logic                   m_last_of_run;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;

    sobel_scoreboard sb = new();

    sobel_edge_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_value  (m_edge_value),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_result(m_edge_value, m_out_col, m_out_row, m_last_of_run);
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idle_mode(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 62;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 62;
            end
            default: begin
                send_idle_pct = 24;
                stall_pct     = 24;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [GRAY_W-1:0] red, input logic [GRAY_W-1:0] green,
                              input logic [GRAY_W-1:0] blue);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= red;
        s_green_in <= green;
        s_blue_in  <= blue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pixel(red, green, blue);
    endtask

    function automatic logic [GRAY_W-1:0] pick_level(level_style_t style);
        case (style)
            LEVELS_EXTREME: return $urandom_range(1) ? SAT_VALUE : '0;
            LEVELS_FLAT:    return GRAY_W'($urandom_range(104, 96));
            default:        return GRAY_W'($urandom_range(255));
        endcase
    endfunction

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_pixels(int count, level_style_t style, bit pauses);
        for (int i = 0; i < count; i++) begin
            send_pixel(pick_level(style), pick_level(style), pick_level(style));
            if (pauses && $urandom_range(199) == 0) drain_results();
        end
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(index, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int           w_cfg;
        int           h_cfg;
        int           total;
        int           random_sent;
        level_style_t style;
        sb.reset_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle_mode(IDLE_NONE);
        cfg_write(REG_FRAME_WIDTH, 13'd3);
        cfg_write(REG_FRAME_HEIGHT, 13'd3);
        foreach (CORNER_FRAME[i])
            send_pixel(CORNER_FRAME[i][23:16], CORNER_FRAME[i][15:8], CORNER_FRAME[i][7:0]);
        foreach (STEP_FRAME[i])
            send_pixel(STEP_FRAME[i][23:16], STEP_FRAME[i][15:8], STEP_FRAME[i][7:0]);
        drain_results();

        // sizes below the minimum clamp to 3; unmapped indexes must not restart
        cfg_write(REG_FRAME_WIDTH, 13'd0);
        cfg_write(REG_FRAME_HEIGHT, 13'd2);
        send_pixels(4, LEVELS_EXTREME, 1'b0);
        drain_results();
        cfg_write(REG_SPARE_LOW, '1);
        cfg_write(REG_SPARE_HIGH, '0);
        send_pixels(5, LEVELS_EXTREME, 1'b0);
        drain_results();

        // output held off while the sender keeps pushing
        cfg_write(REG_FRAME_WIDTH, 13'd6);
        cfg_write(REG_FRAME_HEIGHT, 13'd5);
        hold_request = 1'b1;
        send_pixels(30, LEVELS_RANDOM, 1'b0);
        drain_results();

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            w_cfg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(9, 3);
            h_cfg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
            if ($urandom_range(1)) begin
                cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(w_cfg));
                cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h_cfg));
            end else begin
                cfg_write(REG_FRAME_HEIGHT, CFG_DATA_W'(h_cfg));
                cfg_write(REG_FRAME_WIDTH, CFG_DATA_W'(w_cfg));
            end
            set_idle_mode(idle_mode_t'($urandom_range(3)));
            style = level_style_t'($urandom_range(2));
            total = $urandom_range(2, 1) * (w_cfg < MIN_SIZE ? MIN_SIZE : w_cfg)
                    * (h_cfg < MIN_SIZE ? MIN_SIZE : h_cfg);
            // broken frame: cut short, next register write restarts it
            if ($urandom_range(9) == 0) total = $urandom_range(total - 1, 1);
            send_pixels(total, style, 1'b1);
            random_sent += total;
            drain_results();
        end

        drain_results();
        sb.check_leftover();
        $display("Sent %0d pixels, checked %0d results, %0d register writes.",
                 sb.pixels, sb.checked, sb.reg_writes);
        $display("Frames from clamped 3x3 up to 9x6, with gaps, stalls and a long hold.");
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d results still expected", sb.pending.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sobel_edge_detector.f =====
design/sobel_pkg.sv
design/sobel_queue.sv
design/sobel_front.sv
design/sobel_back.sv
design/sobel_edge_detector.sv
tb/sv/tb_sobel_edge_detector.sv
